### hdl/rm2q_pkg.sv
// ----------------------------------------------------------------------------
// rm2q_pkg
// Shared defaults and codes for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rm2q_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	// Branch taken: positive trace, or the largest diagonal entry.
	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} case_t;

endpackage

### hdl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts one 3x3 rotation matrix per item into the equivalent quaternion,
// all values signed fixed point, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | m00 m01 m02 m10 m11 m12 m20 m21 m22
//  out     | out_valid / out_ready  | qx qy qz qw case_taken radicand_clamped
//
// One item enters per cycle while the full pipeline is not stalled. RH is the
// root width (one square-root bit per stage) and DW = DATA_WIDTH+FRAC_BITS+2
// is the quotient width (one division bit per stage), 32 bits at defaults.
// Reset clears only the valid bits. A stalled output holds its item while
// empty stages upstream keep filling, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = rm2q_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rm2q_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] qx,
	output logic signed [DATA_WIDTH-1:0] qy,
	output logic signed [DATA_WIDTH-1:0] qz,
	output logic signed [DATA_WIDTH-1:0] qw,
	output logic [1:0]                   case_taken,
	output logic                         radicand_clamped
);
	import rm2q_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int SW   = ((W > F) ? W : F) + 3;     // signed radicand sums
	localparam int NW   = SW - 1 + F;                // radicand shifted by F
	localparam int NE   = NW + (NW % 2);
	localparam int RH   = NE / 2;                    // root width
	localparam int MW   = W + 1;                     // numerator magnitude
	localparam int DW   = MW + F + 1;                // dividend and quotient
	localparam int IS2  = 1;
	localparam int ISQ  = 2;
	localparam int IPP  = ISQ + RH;
	localparam int IDV  = IPP + 1;
	localparam int IOUT = IDV + DW;
	localparam int NST  = IOUT + 1;

	localparam logic signed [SW-1:0] ONE   = SW'(1) <<< F;
	localparam logic [DW-1:0]        POS_LIM = (DW'(1) << (W - 1)) - DW'(1);
	localparam logic [DW-1:0]        NEG_LIM = DW'(1) << (W - 1);

	logic [NST-1:0] vld;
	logic [NST-1:0] ld;

	always_comb begin
		ld[NST-1] = !vld[NST-1] || out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			ld[k] = !vld[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (ld[k]) begin
					vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld[IOUT];

	// ---------------- stage 1: sums, differences, diagonal compares
	logic                   tpos_s1, c10_s1, c20_s1, c21_s1;
	logic signed [SW-1:0]   rt_s1, r0_s1, r1_s1, r2_s1;
	logic signed [W:0]      s01_s1, s02_s1, s12_s1, d21_s1, d02_s1, d10_s1;
	logic signed [SW-1:0]   e00, e11, e22, trace;

	assign e00   = SW'(m00);
	assign e11   = SW'(m11);
	assign e22   = SW'(m22);
	assign trace = e00 + e11 + e22;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			tpos_s1 <= trace > 0;
			c10_s1  <= m11 > m00;
			c20_s1  <= m22 > m00;
			c21_s1  <= m22 > m11;
			rt_s1   <= trace + ONE;
			r0_s1   <= e00 - e11 - e22 + ONE;
			r1_s1   <= e11 - e22 - e00 + ONE;
			r2_s1   <= e22 - e00 - e11 + ONE;
			s01_s1  <= (W+1)'(m01) + (W+1)'(m10);
			s02_s1  <= (W+1)'(m02) + (W+1)'(m20);
			s12_s1  <= (W+1)'(m12) + (W+1)'(m21);
			d21_s1  <= (W+1)'(m21) - (W+1)'(m12);
			d02_s1  <= (W+1)'(m02) - (W+1)'(m20);
			d10_s1  <= (W+1)'(m10) - (W+1)'(m01);
		end
	end

	// ---------------- stage 2: branch select, clamp, sign and magnitude
	case_t                 case_n;
	logic signed [SW-1:0]  rsel;
	logic signed [W:0]     nsel [3];
	logic [1:0]            ipick;
	logic                  clamp_n;

	always_comb begin
		ipick = c10_s1 ? 2'd1 : 2'd0;
		if ((ipick == 2'd0) ? c20_s1 : c21_s1) begin
			ipick = 2'd2;
		end
		if (tpos_s1) begin
			case_n  = CASE_TRACE;
			rsel    = rt_s1;
			nsel[0] = d21_s1;
			nsel[1] = d02_s1;
			nsel[2] = d10_s1;
		end else begin
			unique case (ipick)
				2'd1: begin
					case_n  = CASE_Y;
					rsel    = r1_s1;
					nsel[0] = s12_s1;
					nsel[1] = s01_s1;
					nsel[2] = d02_s1;
				end
				2'd2: begin
					case_n  = CASE_Z;
					rsel    = r2_s1;
					nsel[0] = s02_s1;
					nsel[1] = s12_s1;
					nsel[2] = d10_s1;
				end
				default: begin
					case_n  = CASE_X;
					rsel    = r0_s1;
					nsel[0] = s01_s1;
					nsel[1] = s02_s1;
					nsel[2] = d21_s1;
				end
			endcase
		end
		clamp_n = !tpos_s1 && (rsel < 0);
	end

	case_t           case_s2;
	logic            clamp_s2;
	logic [SW-2:0]   rad_s2;
	logic [2:0]      sgn_s2;
	logic [MW-1:0]   mag_s2 [3];

	always_ff @(posedge clk) begin
		if (ld[IS2]) begin
			case_s2  <= case_n;
			clamp_s2 <= clamp_n;
			rad_s2   <= clamp_n ? '0 : rsel[SW-2:0];
			for (int c = 0; c < 3; c++) begin
				sgn_s2[c] <= nsel[c][W];
				mag_s2[c] <= nsel[c][W] ? MW'(-nsel[c]) : MW'(nsel[c]);
			end
		end
	end

	// ---------------- square root, one root bit per stage
	logic [RH+2:0]  sq_rem_s  [RH];
	logic [RH-1:0]  sq_root_s [RH];
	logic [NE-1:0]  sq_n_s    [RH];
	case_t          sq_case_s [RH];
	logic           sq_clamp_s[RH];
	logic [2:0]     sq_sgn_s  [RH];
	logic [MW-1:0]  sq_mag_s  [RH][3];

	for (genvar t = 0; t < RH; t++) begin : g_sqrt
		logic [RH+2:0] rem_i, trial, sub;
		logic [RH-1:0] root_i;
		logic [NE-1:0] n_i;
		case_t         case_i;
		logic          clamp_i;
		logic [2:0]    sgn_i;
		logic [MW-1:0] mag_i [3];
		logic          ge;

		if (t == 0) begin : g_first
			assign rem_i   = '0;
			assign root_i  = '0;
			assign n_i     = NE'(rad_s2) << F;
			assign case_i  = case_s2;
			assign clamp_i = clamp_s2;
			assign sgn_i   = sgn_s2;
			assign mag_i   = mag_s2;
		end else begin : g_next
			assign rem_i   = sq_rem_s[t-1];
			assign root_i  = sq_root_s[t-1];
			assign n_i     = sq_n_s[t-1];
			assign case_i  = sq_case_s[t-1];
			assign clamp_i = sq_clamp_s[t-1];
			assign sgn_i   = sq_sgn_s[t-1];
			assign mag_i   = sq_mag_s[t-1];
		end

		assign trial = {rem_i[RH:0], n_i[NE-1 -: 2]};
		assign sub   = (RH+3)'({root_i, 2'b01});
		assign ge    = trial >= sub;

		always_ff @(posedge clk) begin
			if (ld[ISQ+t]) begin
				sq_rem_s[t]   <= ge ? trial - sub : trial;
				sq_root_s[t]  <= {root_i[RH-2:0], ge};
				sq_n_s[t]     <= n_i << 2;
				sq_case_s[t]  <= case_i;
				sq_clamp_s[t] <= clamp_i;
				sq_sgn_s[t]   <= sgn_i;
				sq_mag_s[t]   <= mag_i;
			end
		end
	end

	// ---------------- dividend preparation: (mag << F) + root rounds to nearest
	logic [DW-1:0]  pp_num_s [3];
	logic [RH-1:0]  pp_root_s;
	case_t          pp_case_s;
	logic           pp_clamp_s;
	logic [2:0]     pp_sgn_s;

	always_ff @(posedge clk) begin
		if (ld[IPP]) begin
			for (int c = 0; c < 3; c++) begin
				pp_num_s[c] <= (DW'(sq_mag_s[RH-1][c]) << F) + DW'(sq_root_s[RH-1]);
			end
			pp_root_s  <= sq_root_s[RH-1];
			pp_case_s  <= sq_case_s[RH-1];
			pp_clamp_s <= sq_clamp_s[RH-1];
			pp_sgn_s   <= sq_sgn_s[RH-1];
		end
	end

	// ---------------- three restoring dividers by 2*root, one bit per stage
	logic [RH:0]    dv_rem_s  [DW][3];
	logic [DW-1:0]  dv_quo_s  [DW][3];
	logic [DW-1:0]  dv_num_s  [DW][3];
	logic [RH-1:0]  dv_root_s [DW];
	case_t          dv_case_s [DW];
	logic           dv_clamp_s[DW];
	logic [2:0]     dv_sgn_s  [DW];

	for (genvar t = 0; t < DW; t++) begin : g_div
		logic [RH:0]   rem_i [3];
		logic [DW-1:0] quo_i [3];
		logic [DW-1:0] num_i [3];
		logic [RH-1:0] root_i;
		case_t         case_i;
		logic          clamp_i;
		logic [2:0]    sgn_i;
		logic [RH+1:0] den;

		if (t == 0) begin : g_first
			assign rem_i   = '{default: '0};
			assign quo_i   = '{default: '0};
			assign num_i   = pp_num_s;
			assign root_i  = pp_root_s;
			assign case_i  = pp_case_s;
			assign clamp_i = pp_clamp_s;
			assign sgn_i   = pp_sgn_s;
		end else begin : g_next
			assign rem_i   = dv_rem_s[t-1];
			assign quo_i   = dv_quo_s[t-1];
			assign num_i   = dv_num_s[t-1];
			assign root_i  = dv_root_s[t-1];
			assign case_i  = dv_case_s[t-1];
			assign clamp_i = dv_clamp_s[t-1];
			assign sgn_i   = dv_sgn_s[t-1];
		end

		assign den = {1'b0, root_i, 1'b0};

		for (genvar c = 0; c < 3; c++) begin : g_lane
			logic [RH+1:0] trial;
			logic          ge;

			assign trial = {rem_i[c], num_i[c][DW-1]};
			assign ge    = trial >= den;

			always_ff @(posedge clk) begin
				if (ld[IDV+t]) begin
					dv_rem_s[t][c] <= ge ? (RH+1)'(trial - den) : trial[RH:0];
					dv_quo_s[t][c] <= {quo_i[c][DW-2:0], ge};
					dv_num_s[t][c] <= num_i[c] << 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[IDV+t]) begin
				dv_root_s[t]  <= root_i;
				dv_case_s[t]  <= case_i;
				dv_clamp_s[t] <= clamp_i;
				dv_sgn_s[t]   <= sgn_i;
			end
		end
	end

	// ---------------- saturation and component placement
	function automatic logic [W-1:0] sat_mag(input logic neg, input logic [DW-1:0] mag);
		logic [W-1:0] res;
		if (!neg) begin
			res = (mag > POS_LIM) ? POS_LIM[W-1:0] : mag[W-1:0];
		end else begin
			res = (mag > NEG_LIM) ? NEG_LIM[W-1:0] : W'(-mag);
		end
		return res;
	endfunction

	logic [W-1:0]  diag_v;
	logic [W-1:0]  scl_v [3];
	logic [RH-1:0] root_f;
	case_t         case_f;

	assign root_f = dv_root_s[DW-1];
	assign case_f = dv_case_s[DW-1];
	assign diag_v = sat_mag(1'b0, DW'(root_f >> 1));

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			// A zero root forces the scaled components to zero.
			scl_v[c] = (root_f == '0) ? '0 : sat_mag(dv_sgn_s[DW-1][c], dv_quo_s[DW-1][c]);
		end
	end

	logic [W-1:0] qx_q, qy_q, qz_q, qw_q;
	case_t        case_q;
	logic         clamp_q;

	always_ff @(posedge clk) begin
		if (ld[IOUT]) begin
			case_q  <= case_f;
			clamp_q <= dv_clamp_s[DW-1];
			unique case (case_f)
				CASE_X: begin
					qx_q <= diag_v;   qy_q <= scl_v[0]; qz_q <= scl_v[1]; qw_q <= scl_v[2];
				end
				CASE_Y: begin
					qy_q <= diag_v;   qz_q <= scl_v[0]; qx_q <= scl_v[1]; qw_q <= scl_v[2];
				end
				CASE_Z: begin
					qz_q <= diag_v;   qx_q <= scl_v[0]; qy_q <= scl_v[1]; qw_q <= scl_v[2];
				end
				default: begin
					qw_q <= diag_v;   qx_q <= scl_v[0]; qy_q <= scl_v[1]; qz_q <= scl_v[2];
				end
			endcase
		end
	end

	assign qx               = qx_q;
	assign qy               = qy_q;
	assign qz               = qz_q;
	assign qw               = qw_q;
	assign case_taken       = case_q;
	assign radicand_clamped = clamp_q;

	// ---------------- assertions
	a_clamp_not_trace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(radicand_clamped && case_taken == CASE_TRACE))
		else $error("clamp flagged on the positive trace path");

	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && radicand_clamped |-> qx == '0 && qy == '0 && qz == '0 && qw == '0)
		else $error("clamped radicand gave a nonzero quaternion");

	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && case_taken == CASE_TRACE |-> !qw[W-1])
		else $error("negative w on the positive trace path");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld[0])
		else $error("accepted item missing from the first stage");

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the rotation matrix to quaternion converter against a behavioral
// predictor: directed corner matrices, then random rotations and raw noise,
// with random input bursts and output back-pressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rm2q_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam longint QMAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint QMIN = -(longint'(1) << (DW - 1));

	typedef logic signed [DW-1:0] word_t;
	typedef word_t mat_t [9];

	typedef struct packed {
		word_t qx;
		word_t qy;
		word_t qz;
		word_t qw;
		case_t ct;
		logic  clamp;
	} quat_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	word_t qx, qy, qz, qw;
	logic [1:0] case_taken;
	logic radicand_clamped;

	quat_t expected_quats[$];
	int errors = 0;
	int stall_mode = 0;

	rotation_matrix_to_quaternion i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.out_valid(out_valid), .out_ready(out_ready),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw),
		.case_taken(case_taken), .radicand_clamped(radicand_clamped)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint int_sqrt(longint n);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	// Off-diagonal term times ONE over twice the root, rounded half away from zero.
	function automatic longint scale_term(longint num, longint root);
		longint mag, den, q;
		if (root == 0) return 0;
		mag = (num < 0 ? -num : num) << FB;
		den = root * 2;
		q = (mag + (den >>> 1)) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic word_t sat(longint v);
		if (v > QMAX) return word_t'(QMAX);
		if (v < QMIN) return word_t'(QMIN);
		return word_t'(v);
	endfunction

	function automatic quat_t matrix_to_quat(mat_t mv);
		longint m[3][3];
		longint q[4];
		longint tr, rad, root;
		int i, j, k;
		int nxt[3];
		quat_t res;
		nxt = '{1, 2, 0};
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				m[r][c] = longint'(mv[r*3+c]);
		tr = m[0][0] + m[1][1] + m[2][2];
		res.clamp = 1'b0;
		if (tr > 0) begin
			root = int_sqrt((tr + ONE) << FB);
			q[3] = root >>> 1;
			q[0] = scale_term(m[2][1] - m[1][2], root);
			q[1] = scale_term(m[0][2] - m[2][0], root);
			q[2] = scale_term(m[1][0] - m[0][1], root);
			res.ct = CASE_TRACE;
		end else begin
			i = (m[1][1] > m[0][0]) ? 1 : 0;
			i = (m[2][2] > m[i][i]) ? 2 : i;
			j = nxt[i];
			k = nxt[j];
			rad = m[i][i] - m[j][j] - m[k][k] + ONE;
			if (rad < 0) begin
				rad = 0;
				res.clamp = 1'b1;
			end
			root = int_sqrt(rad << FB);
			q[i] = root >>> 1;
			q[j] = scale_term(m[i][j] + m[j][i], root);
			q[k] = scale_term(m[i][k] + m[k][i], root);
			q[3] = scale_term(m[k][j] - m[j][k], root);
			res.ct = (i == 0) ? CASE_X : (i == 1) ? CASE_Y : CASE_Z;
		end
		res.qx = sat(q[0]);
		res.qy = sat(q[1]);
		res.qz = sat(q[2]);
		res.qw = sat(q[3]);
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Sends one item, honoring the burst/gap pattern. Valid stays high after
	// an accepted item until the next item or a gap replaces it in the same
	// time step.
	task automatic send_matrix(mat_t mv);
		if ($urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
			{mv[0], mv[1], mv[2], mv[3], mv[4], mv[5], mv[6], mv[7], mv[8]};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_quats.push_back(matrix_to_quat(mv));
	endtask

	always @(posedge clk) begin
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 2) == 0);
		endcase
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_quats.size() == 0) begin
				report_mismatch("unexpected result count", 1, 0);
			end else begin
				want = expected_quats.pop_front();
				if (qx !== want.qx) report_mismatch("qx", qx, want.qx);
				if (qy !== want.qy) report_mismatch("qy", qy, want.qy);
				if (qz !== want.qz) report_mismatch("qz", qz, want.qz);
				if (qw !== want.qw) report_mismatch("qw", qw, want.qw);
				if (case_taken !== want.ct)
					report_mismatch("case_taken", case_taken, want.ct);
				if (radicand_clamped !== want.clamp)
					report_mismatch("radicand_clamped", radicand_clamped, want.clamp);
			end
		end
	end

	function automatic word_t rnd_word();
		return word_t'($urandom());
	endfunction

	// Noise of -4 to +4 LSB on each entry of a proper rotation keeps the trace paths realistic.
	function automatic mat_t random_rotation();
		mat_t mv;
		real a, b, c, ca, sa, cb, sb, cc, sc, r[9];
		a = ($urandom_range(0, 62831) / 10000.0);
		b = ($urandom_range(0, 62831) / 10000.0);
		c = ($urandom_range(0, 62831) / 10000.0);
		ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b);
		cc = $cos(c); sc = $sin(c);
		r = '{ca*cb, ca*sb*sc - sa*cc, ca*sb*cc + sa*sc,
			sa*cb, sa*sb*sc + ca*cc, sa*sb*cc - ca*sc,
			-sb, cb*sc, cb*cc};
		for (int n = 0; n < 9; n++)
			mv[n] = word_t'($rtoi(r[n] * ONE) + $signed($urandom_range(0, 8)) - 4);
		return mv;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_quats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_directed();
		mat_t mv;
		word_t mx, mn;
		mx = word_t'(QMAX);
		mn = word_t'(QMIN);
		mv = '{word_t'(ONE), 0, 0, 0, word_t'(ONE), 0, 0, 0, word_t'(ONE)};
		send_matrix(mv);
		// Half turns about each axis take the diagonal branches.
		mv = '{word_t'(ONE), 0, 0, 0, -word_t'(ONE), 0, 0, 0, -word_t'(ONE)};
		send_matrix(mv);
		mv = '{-word_t'(ONE), 0, 0, 0, word_t'(ONE), 0, 0, 0, -word_t'(ONE)};
		send_matrix(mv);
		mv = '{-word_t'(ONE), 0, 0, 0, -word_t'(ONE), 0, 0, 0, word_t'(ONE)};
		send_matrix(mv);
		// Zero matrix: tie on the diagonal keeps x.
		mv = '{default: 0};
		send_matrix(mv);
		// Tie between y and z keeps y.
		mv = '{-word_t'(ONE), 5, 7, 9, 0, 11, 13, 15, 0};
		send_matrix(mv);
		// Extreme diagonal entries give the largest radicands.
		mv = '{mn, 1, 2, 3, mn, 4, 5, 6, mx};
		send_matrix(mv);
		mv = '{0, 0, 0, 0, mx, 0, 0, 0, mx};
		send_matrix(mv);
		// Saturating outputs from extreme entries.
		mv = '{1, mn, mx, mx, 0, mn, mn, mx, 0};
		send_matrix(mv);
		mv = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
		send_matrix(mv);
		mv = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
		send_matrix(mv);
		mv = '{mx, mn, mx, mn, mn, mx, mn, mx, mn};
		send_matrix(mv);
		mv = '{-1, mx, mn, mn, -1, mx, mx, mn, -1};
		send_matrix(mv);
		mv = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(mv);
	endtask

	task automatic test_random(int n_items);
		mat_t mv;
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				for (int e = 0; e < 9; e++) mv[e] = rnd_word();
			end else begin
				mv = random_rotation();
			end
			send_matrix(mv);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		stall_mode = 1;
		test_random(900);
		drain();
		stall_mode = 2;
		test_random(600);
		stall_mode = 0;
		test_random(350);
		drain();
		if (errors == 0 && expected_quats.size() == 0)
			$display("rotation_matrix_to_quaternion test passed");
		else
			$display("rotation_matrix_to_quaternion test failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("rotation_matrix_to_quaternion test failed");
		$finish;
	end

endmodule

### files.f
hdl/rm2q_pkg.sv
hdl/rotation_matrix_to_quaternion.sv
dv/tb.sv
